@@ sv/sb2dec_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2dec_pkg
// shared constants and controller/datapath interface types for the signed
// binary to decimal ascii converter
// ----------------------------------------------------------------------------
package sb2dec_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int CHAR_W         = 8;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } sb2dec_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic negative;
        logic top_zero;
        logic rem_one;
        logic out_free;
    } sb2dec_status_t;

endpackage
`default_nettype wire

@@ sv/sb2dec_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2dec_ctrl
// sequencer: accept, shift-add-3 conversion, leading zero skip, sign and
// digit transfers
// ----------------------------------------------------------------------------
module sb2dec_ctrl #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    input  wire sb2dec_pkg::sb2dec_status_t status,
    output sb2dec_pkg::sb2dec_cmd_t         cmd
);
    import sb2dec_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = CNT_W'(VALUE_BITS - 1);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_SKIP: begin
                if (status.top_zero && !status.rem_one) begin
                    cmd.skip = 1'b1;
                end else if (status.negative) begin
                    state_next = ST_SIGN;
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (status.out_free) begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (status.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (status.rem_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/sb2dec_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2dec_dp
// datapath: magnitude and bcd shift registers, digit count and the output
// register of the character stream
// ----------------------------------------------------------------------------
module sb2dec_dp #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    output logic [sb2dec_pkg::CHAR_W-1:0]               m_axis_tdata,
    output logic                                        m_axis_tlast,
    input  wire sb2dec_pkg::sb2dec_cmd_t                cmd,
    output sb2dec_pkg::sb2dec_status_t                  status
);
    import sb2dec_pkg::*;

    localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BCD_W  = DIGITS * 4;
    localparam int REM_W  = $clog2(DIGITS + 1);

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]      bcd_reg, bcd_next;
    logic [BCD_W-1:0]      bcd_adj;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] raw;
    logic [3:0]            top_digit;

    logic              m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    assign raw       = s_axis_tdata[VALUE_BITS-1:0];
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd_reg[i*4 +: 4] >= 4'd5) begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
            end
        end
    end

    always_comb begin
        mag_next     = mag_reg;
        bcd_next     = bcd_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.load) begin
            neg_next = raw[VALUE_BITS-1];
            mag_next = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
            bcd_next = '0;
            rem_next = REM_W'(DIGITS);
        end
        if (cmd.step) begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
        end
        if (cmd.skip) begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next = rem_reg - REM_W'(1);
        end
        if (cmd.emit_sign) begin
            m_valid_next = 1'b1;
            m_data_next  = CHAR_MINUS;
            m_last_next  = 1'b0;
        end
        if (cmd.emit_digit) begin
            m_valid_next = 1'b1;
            m_data_next  = CHAR_ZERO + {4'd0, top_digit};
            m_last_next  = (rem_reg == REM_W'(1));
            bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
            rem_next     = rem_reg - REM_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        mag_reg    <= mag_next;
        bcd_reg    <= bcd_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign status.negative = neg_reg;
    assign status.top_zero = (top_digit == 4'd0);
    assign status.rem_one  = (rem_reg == REM_W'(1));
    assign status.out_free = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule
`default_nettype wire

@@ sv/signed_binary_to_decimal_ascii_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_core
// converts a signed integer into its decimal ascii text, one character per
// transfer
// ----------------------------------------------------------------------------
// One transfer in gives a run of characters out: '-' for a negative value,
// then the digits most significant first with no leading zeros (zero gives a
// single '0'); tlast marks the final character. The most negative value
// converts as usual. Per item: accept, then one shift-add-3 step per value
// bit on the bcd register, then drop leading zero digits one per cycle with
// a final check, then send one character per cycle with no back-pressure.
// The final character waits in the output register while the next value is
// already accepted.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_core #(
    parameter int VALUE_BITS = sb2dec_pkg::VALUE_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // character
    output logic [sb2dec_pkg::CHAR_W-1:0]           m_axis_tdata,
    output logic                                    m_axis_tlast
);
    import sb2dec_pkg::*;

    sb2dec_cmd_t    cmd;
    sb2dec_status_t status;

    sb2dec_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    sb2dec_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

endmodule
`default_nettype wire
